### sv/xtv_pkg.sv
package xtv_pkg;

   // Sizing of the tag, the value and the document
   localparam int MAX_TAG_BYTES      = 32;
   localparam int MAX_VALUE_BYTES    = 1024;
   localparam int MAX_DOCUMENT_BYTES = 65536;

   localparam int TAG_LEN_W  = 6;
   localparam int LIMIT_W    = 11;
   localparam int BYTE_IDX_W = 17;
   localparam int POS_W      = 18;

   // One input byte gives at most this many result words
   localparam int MAX_RESULTS = 3;

   // Result queue
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   // Configuration register indexes
   localparam logic [2:0] CSR_TAG_0_7   = 3'd0;
   localparam logic [2:0] CSR_TAG_8_15  = 3'd1;
   localparam logic [2:0] CSR_TAG_16_23 = 3'd2;
   localparam logic [2:0] CSR_TAG_24_31 = 3'd3;
   localparam logic [2:0] CSR_TAG_LEN   = 3'd4;
   localparam logic [2:0] CSR_LIMIT     = 3'd5;

   // Configuration as seen by the scanner (lengths already clamped)
   typedef struct packed {
      logic [MAX_TAG_BYTES-1:0][7:0] tag;
      logic [TAG_LEN_W-1:0]          tag_len;
      logic [LIMIT_W-1:0]            limit;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic                    result_kind;
      logic [7:0]              value_byte;
      logic [1:0]              finish_status;
      logic signed [POS_W-1:0] end_position;
      logic                    last_result;
   } rsp_word_type;

   // Result words produced by one accepted byte
   typedef struct packed {
      logic [1:0]                         count;
      rsp_word_type [MAX_RESULTS-1:0]     word;
   } push_type;

endpackage

### sv/xtv_if.sv
interface xtv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface xtv_rsp_if;
   logic                    valid;
   logic                    ready;
   logic                    result_kind;
   logic [7:0]              value_byte;
   logic [1:0]              finish_status;
   logic signed [17:0]      end_position;
   logic                    last_result;

   modport source (output valid, output result_kind, output value_byte,
                   output finish_status, output end_position, output last_result,
                   input ready);
   modport sink   (input valid, input result_kind, input value_byte,
                   input finish_status, input end_position, input last_result,
                   output ready);
endinterface

interface xtv_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/xml_tag_value_extractor.sv
// Extracts the text of the first element with a configured opening tag from a
// byte stream, one document at a time (last_byte closes a document). Each
// value byte comes out as a word with result_kind 0, and every document ends
// in exactly one report word (result_kind 1, last_result 1) giving the
// status and the end position, or -1 when the tag was never seen. A '<' in
// the value is held for one byte to look for "</". One byte is taken per
// clock; a byte can give up to three words, and the result side, when ready,
// drains one word per clock from an eight-word queue, so req ready drops only
// while the queue holds more than five words. The csr port writes at any time
// (ready is always high) and should be used only while the block is idle.
module xml_tag_value_extractor (
   input  logic       clock,
   input  logic       reset,
   xtv_req_if.sink    req_ch,
   xtv_rsp_if.source  rsp_ch,
   xtv_csr_if.sink    csr_ch
);

   xtv_pkg::cfg_type       cfg_ff, cfg_in;
   xtv_pkg::push_type      push;
   xtv_pkg::rsp_word_type  head;
   logic                   room;
   logic                   not_empty;
   logic                   fire;
   logic [5:0]             len_wr;
   logic [10:0]            lim_wr;

   assign req_ch.ready = room;
   assign fire         = req_ch.valid & room;
   assign csr_ch.ready = 1'b1;

   // Register writes, lengths clamped on the way in
   assign len_wr = csr_ch.data[5:0];
   assign lim_wr = csr_ch.data[10:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            xtv_pkg::CSR_TAG_0_7:   cfg_in.tag[7:0]   = csr_ch.data;
            xtv_pkg::CSR_TAG_8_15:  cfg_in.tag[15:8]  = csr_ch.data;
            xtv_pkg::CSR_TAG_16_23: cfg_in.tag[23:16] = csr_ch.data;
            xtv_pkg::CSR_TAG_24_31: cfg_in.tag[31:24] = csr_ch.data;
            xtv_pkg::CSR_TAG_LEN: begin
               if (len_wr == '0) begin
                  cfg_in.tag_len = 6'd1;
               end else if (len_wr > 6'(xtv_pkg::MAX_TAG_BYTES)) begin
                  cfg_in.tag_len = 6'(xtv_pkg::MAX_TAG_BYTES);
               end else begin
                  cfg_in.tag_len = len_wr;
               end
            end
            xtv_pkg::CSR_LIMIT: begin
               if (lim_wr > 11'(xtv_pkg::MAX_VALUE_BYTES)) begin
                  cfg_in.limit = 11'(xtv_pkg::MAX_VALUE_BYTES);
               end else begin
                  cfg_in.limit = lim_wr;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tag     <= '0;
         cfg_ff.tag_len <= 6'd1;
         cfg_ff.limit   <= 11'(xtv_pkg::MAX_VALUE_BYTES);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   xtv_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (req_ch.data_byte),
      .last_byte (req_ch.last_byte),
      .cfg       (cfg_ff),
      .push      (push)
   );

   xtv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (not_empty & rsp_ch.ready),
      .room      (room),
      .not_empty (not_empty),
      .head      (head)
   );

   // Result channel straight from the queue head
   assign rsp_ch.valid         = not_empty;
   assign rsp_ch.result_kind   = head.result_kind;
   assign rsp_ch.value_byte    = head.value_byte;
   assign rsp_ch.finish_status = head.finish_status;
   assign rsp_ch.end_position  = head.end_position;
   assign rsp_ch.last_result   = head.last_result;

endmodule

### sv/xtv_scan.sv
module xtv_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   input  xtv_pkg::cfg_type   cfg,
   output xtv_pkg::push_type  push
);

   typedef enum logic [2:0] {
      PH_SEARCH = 3'b001,
      PH_VALUE  = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_CLOSED   = 2'd0,
      ST_TRUNC    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_ENDED    = 2'd3
   } status_type;

   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [7:0] CH_OPEN  = 8'h3C;   // '<'
   localparam logic [7:0] CH_SLASH = 8'h2F;   // '/'

   localparam logic [xtv_pkg::POS_W-1:0] POS_CAP =
      xtv_pkg::POS_W'(xtv_pkg::MAX_DOCUMENT_BYTES);
   localparam logic [xtv_pkg::BYTE_IDX_W-1:0] IDX_CAP =
      xtv_pkg::BYTE_IDX_W'(xtv_pkg::MAX_DOCUMENT_BYTES);
   localparam logic [xtv_pkg::POS_W-1:0] POS_NONE = '1;

   function automatic logic [xtv_pkg::POS_W-1:0] cap_pos(
      input logic [xtv_pkg::POS_W-1:0] v);
      return (v > POS_CAP) ? POS_CAP : v;
   endfunction

   function automatic xtv_pkg::rsp_word_type mk_value(input logic [7:0] b);
      xtv_pkg::rsp_word_type w;
      w.result_kind   = KIND_VALUE;
      w.value_byte    = b;
      w.finish_status = ST_CLOSED;
      w.end_position  = '0;
      w.last_result   = 1'b0;
      return w;
   endfunction

   function automatic xtv_pkg::rsp_word_type mk_report(
      input status_type st, input logic [xtv_pkg::POS_W-1:0] pos);
      xtv_pkg::rsp_word_type w;
      w.result_kind   = KIND_REPORT;
      w.value_byte    = 8'd0;
      w.finish_status = st;
      w.end_position  = pos;
      w.last_result   = 1'b1;
      return w;
   endfunction

   phase_type                       phase_ff, phase_in;
   logic [xtv_pkg::TAG_LEN_W-1:0]   match_ff, match_in;
   logic [xtv_pkg::BYTE_IDX_W-1:0]  index_ff, index_in;
   logic [xtv_pkg::LIMIT_W-1:0]     vcount_ff, vcount_in;
   logic                            held_ff, held_in;

   logic [7:0]                      tag_cur;
   logic [xtv_pkg::POS_W-1:0]       pos_here, pos_after, pos_prev;
   logic                            go_on;
   status_type                      end_st;
   logic [1:0]                      n;
   xtv_pkg::rsp_word_type [xtv_pkg::MAX_RESULTS-1:0] words;

   // Tag byte under the match pointer; beyond the tag store reads as zero
   assign tag_cur = match_ff[xtv_pkg::TAG_LEN_W-1] ? 8'd0 :
                    cfg.tag[match_ff[xtv_pkg::TAG_LEN_W-2:0]];

   assign pos_here  = {1'b0, index_ff};
   assign pos_after = cap_pos(pos_here + 1'b1);
   assign pos_prev  = (index_ff == '0) ? '0 : cap_pos(pos_here - 1'b1);

   // One byte of the document: search, value emission, end of document
   always_comb begin
      phase_in  = phase_ff;
      match_in  = match_ff;
      vcount_in = vcount_ff;
      held_in   = held_ff;
      n         = 2'd0;
      words     = '0;
      go_on     = 1'b1;
      end_st    = ST_ENDED;

      case (phase_ff)
         PH_SEARCH: begin
            if (tag_cur == data_byte) begin
               match_in = match_ff + 1'b1;
               if (match_in >= cfg.tag_len) begin
                  phase_in  = PH_VALUE;
                  vcount_in = '0;
                  held_in   = 1'b0;
                  if (cfg.limit == '0) begin
                     words[n] = mk_report(ST_TRUNC, pos_after);
                     n        = n + 2'd1;
                     phase_in = PH_DONE;
                  end
               end
            end else begin
               match_in = (data_byte == cfg.tag[0]) ? 6'd1 : 6'd0;
            end
         end
         PH_VALUE: begin
            if (held_ff) begin
               held_in = 1'b0;
               if (data_byte == CH_SLASH) begin
                  words[n] = mk_report(ST_CLOSED, pos_prev);
                  n        = n + 2'd1;
                  phase_in = PH_DONE;
                  go_on    = 1'b0;
               end else begin
                  words[n]  = mk_value(CH_OPEN);
                  n         = n + 2'd1;
                  vcount_in = vcount_in + 1'b1;
                  if (vcount_in >= cfg.limit) begin
                     words[n] = mk_report(ST_TRUNC, cap_pos(pos_here));
                     n        = n + 2'd1;
                     phase_in = PH_DONE;
                     go_on    = 1'b0;
                  end
               end
            end
            if (go_on) begin
               if (data_byte == CH_OPEN) begin
                  held_in = 1'b1;
               end else begin
                  words[n]  = mk_value(data_byte);
                  n         = n + 2'd1;
                  vcount_in = vcount_in + 1'b1;
                  if (vcount_in >= cfg.limit) begin
                     words[n] = mk_report(ST_TRUNC, pos_after);
                     n        = n + 2'd1;
                     phase_in = PH_DONE;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // End of document: final report, then rearm
      if (last_byte) begin
         if (phase_in == PH_SEARCH) begin
            words[n] = mk_report(ST_NOTFOUND, POS_NONE);
            n        = n + 2'd1;
         end else if (phase_in == PH_VALUE) begin
            if (held_in) begin
               words[n]  = mk_value(CH_OPEN);
               n         = n + 2'd1;
               vcount_in = vcount_in + 1'b1;
               if (vcount_in >= cfg.limit) begin
                  end_st = ST_TRUNC;
               end
            end
            words[n] = mk_report(end_st, pos_after);
            n        = n + 2'd1;
         end
         phase_in  = PH_SEARCH;
         match_in  = '0;
         vcount_in = '0;
         held_in   = 1'b0;
         index_in  = '0;
      end else begin
         index_in = (index_ff < IDX_CAP) ? index_ff + 1'b1 : index_ff;
      end

      push.count = fire ? n : 2'd0;
      push.word  = words;
   end

   // Scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         match_ff  <= '0;
         index_ff  <= '0;
         vcount_ff <= '0;
         held_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         match_ff  <= match_in;
         index_ff  <= index_in;
         vcount_ff <= vcount_in;
         held_ff   <= held_in;
      end
   end

endmodule

### sv/xtv_fifo.sv
module xtv_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  xtv_pkg::push_type             push,
   input  logic                          pop,
   output logic                          room,
   output logic                          not_empty,
   output xtv_pkg::rsp_word_type         head
);

   xtv_pkg::rsp_word_type mem [xtv_pkg::RSP_FIFO_DEPTH];

   logic [xtv_pkg::RSP_PTR_W-1:0] wr_ff, wr_in;
   logic [xtv_pkg::RSP_PTR_W-1:0] rd_ff, rd_in;
   logic [xtv_pkg::RSP_CNT_W-1:0] count_ff, count_in;

   // Room for the worst case of one byte
   assign room      = count_ff <=
                      xtv_pkg::RSP_CNT_W'(xtv_pkg::RSP_FIFO_DEPTH - xtv_pkg::MAX_RESULTS);
   assign not_empty = count_ff != '0;
   assign head      = mem[rd_ff];

   // Pointer and fill updates
   always_comb begin
      wr_in    = wr_ff + xtv_pkg::RSP_PTR_W'(push.count);
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + xtv_pkg::RSP_CNT_W'(push.count)
                 - xtv_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Up to three words written in one cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < xtv_pkg::MAX_RESULTS; k++) begin
         if (2'(k) < push.count) begin
            mem[wr_ff + xtv_pkg::RSP_PTR_W'(k)] <= push.word[k];
         end
      end
   end

endmodule

### bench/xtv_value_checker.sv
`timescale 1ns / 1ps
// Watches the three channels, keeps its own copy of the extractor's registers
// and scan state, and compares every result word with the words owed.
module xtv_value_checker (
   input  logic clock,
   input  logic reset,
   xtv_req_if   req_ch,
   xtv_rsp_if   rsp_ch,
   xtv_csr_if   csr_ch,
   output int   error_count,
   output int   words_owed
);
   import xtv_pkg::*;

   typedef enum logic [1:0] {SCAN_SEARCH, SCAN_VALUE, SCAN_DONE} scan_phase_e;

   localparam logic [1:0] FIN_CLOSED    = 2'd0;
   localparam logic [1:0] FIN_TRUNC     = 2'd1;
   localparam logic [1:0] FIN_NOT_FOUND = 2'd2;
   localparam logic [1:0] FIN_ENDED     = 2'd3;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // register copy
   logic [63:0]          tag_word [4];
   logic [TAG_LEN_W-1:0] tag_len_r;
   logic [LIMIT_W-1:0]   limit_r;

   // scan state
   scan_phase_e phase;
   int          match_cnt;
   int          byte_idx;
   int          value_cnt;
   bit          held_lt;

   rsp_word_type pending_words [$];
   rsp_word_type got;
   rsp_word_type want;

   function automatic logic [7:0] tag_at(input int k);
      if (k >= MAX_TAG_BYTES) return 8'h00;
      return 8'(tag_word[k >> 3] >> (8 * (k % 8)));
   endfunction

   function automatic int tag_len_eff();
      int n;
      n = tag_len_r;
      if (n == 0) n = 1;
      if (n > MAX_TAG_BYTES) n = MAX_TAG_BYTES;
      return n;
   endfunction

   function automatic int limit_eff();
      int n;
      n = limit_r;
      if (n > MAX_VALUE_BYTES) n = MAX_VALUE_BYTES;
      return n;
   endfunction

   function automatic void rearm();
      phase     = SCAN_SEARCH;
      match_cnt = 0;
      byte_idx  = 0;
      value_cnt = 0;
      held_lt   = 0;
   endfunction

   // value byte word; returns 1 once the limit is reached
   function automatic bit owe_value(input logic [7:0] b);
      rsp_word_type w;
      w            = '0;
      w.value_byte = b;
      pending_words.push_back(w);
      value_cnt++;
      return value_cnt >= limit_eff();
   endfunction

   // completion report, ends the document
   function automatic void owe_report(input logic [1:0] status, input bit found, input int pos);
      rsp_word_type w;
      int capped;
      capped          = (pos > MAX_DOCUMENT_BYTES) ? MAX_DOCUMENT_BYTES : pos;
      w               = '0;
      w.result_kind   = 1'b1;
      w.finish_status = status;
      w.end_position  = found ? POS_W'(capped) : '1;
      w.last_result   = 1'b1;
      pending_words.push_back(w);
      phase = SCAN_DONE;
   endfunction

   // one accepted document byte
   function automatic void scan_byte(input logic [7:0] b, input logic last);
      int here;
      int after;
      bit handle;
      logic [1:0] st;
      here  = byte_idx;
      after = here + 1;
      case (phase)
         SCAN_SEARCH: begin
            if (tag_at(match_cnt) == b) begin
               match_cnt++;
               if (match_cnt >= tag_len_eff()) begin
                  phase     = SCAN_VALUE;
                  value_cnt = 0;
                  held_lt   = 0;
                  if (limit_eff() == 0) owe_report(FIN_TRUNC, 1'b1, after);
               end
            end else begin
               // a breaking byte may itself start a new match
               match_cnt = (b == tag_at(0)) ? 1 : 0;
            end
         end
         SCAN_VALUE: begin
            handle = 1'b1;
            if (held_lt) begin
               held_lt = 0;
               if (b == CHAR_SLASH) begin
                  owe_report(FIN_CLOSED, 1'b1, (here > 0) ? here - 1 : 0);
                  handle = 1'b0;
               end else if (owe_value(CHAR_LT)) begin
                  owe_report(FIN_TRUNC, 1'b1, here);
                  handle = 1'b0;
               end
            end
            if (handle) begin
               if (b == CHAR_LT) held_lt = 1'b1;
               else if (owe_value(b)) owe_report(FIN_TRUNC, 1'b1, after);
            end
         end
         default: ;
      endcase

      if (byte_idx < MAX_DOCUMENT_BYTES) byte_idx++;

      if (last) begin
         if (phase == SCAN_SEARCH) begin
            owe_report(FIN_NOT_FOUND, 1'b0, 0);
         end else if (phase == SCAN_VALUE) begin
            st = FIN_ENDED;
            if (held_lt) begin
               held_lt = 0;
               if (owe_value(CHAR_LT)) st = FIN_TRUNC;
            end
            owe_report(st, 1'b1, after);
         end
         rearm();
      end
   endfunction

   function automatic void write_register(input logic [2:0] idx, input logic [63:0] data);
      case (idx)
         CSR_TAG_0_7:   tag_word[0] = data;
         CSR_TAG_8_15:  tag_word[1] = data;
         CSR_TAG_16_23: tag_word[2] = data;
         CSR_TAG_24_31: tag_word[3] = data;
         CSR_TAG_LEN:   tag_len_r   = data[TAG_LEN_W-1:0];
         CSR_LIMIT:     limit_r     = data[LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // sample all three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         tag_word    = '{default: '0};
         tag_len_r   = TAG_LEN_W'(1);
         limit_r     = LIMIT_W'(MAX_VALUE_BYTES);
         error_count = 0;
         pending_words.delete();
         rearm();
      end else begin
         if (csr_ch.valid && csr_ch.ready) write_register(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) scan_byte(req_ch.data_byte, req_ch.last_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.result_kind   = rsp_ch.result_kind;
            got.value_byte    = rsp_ch.value_byte;
            got.finish_status = rsp_ch.finish_status;
            got.end_position  = rsp_ch.end_position;
            got.last_result   = rsp_ch.last_result;
            if (pending_words.size() == 0) begin
               error_count++;
               $write("%0t: word with none owed: kind %0d byte %02h status %0d",
                      $time, got.result_kind, got.value_byte, got.finish_status);
               $display(" pos %0d last %0d", got.end_position, got.last_result);
            end else begin
               want = pending_words.pop_front();
               if (got !== want) begin
                  error_count++;
                  $write("%0t: word mismatch: expected kind %0d byte %02h status %0d",
                         $time, want.result_kind, want.value_byte, want.finish_status);
                  $write(" pos %0d last %0d, got kind %0d byte %02h status %0d",
                         want.end_position, want.last_result, got.result_kind,
                         got.value_byte, got.finish_status);
                  $display(" pos %0d last %0d", got.end_position, got.last_result);
               end
            end
         end
      end
      words_owed = pending_words.size();
   end

endmodule

### bench/xml_tag_value_extractor_tb.sv
`timescale 1ns / 1ps
module xml_tag_value_extractor_tb;
   import xtv_pkg::*;

   typedef enum logic [1:0] {TAG_RANDOM, TAG_ONES, TAG_KEEP} tag_fill_e;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 55;

   // indexes with no register behind them
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] LETTERS [5] = '{8'h61, 8'h62, 8'h3C, 8'h2F, 8'h63};

   logic clock = 1'b0;
   logic reset;

   xtv_req_if req_ch ();
   xtv_rsp_if rsp_ch ();
   xtv_csr_if csr_ch ();

   int error_count;
   int words_owed;
   int cycle_count = 0;
   int items_sent;
   bit calm;

   // tag as written, kept to build documents around it
   logic [7:0] tag_text [MAX_TAG_BYTES];
   int         tag_len_used;
   logic [7:0] doc [$];

   xml_tag_value_extractor DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   xtv_value_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .error_count (error_count),
      .words_owed  (words_owed)
   );

   always #5 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else       rsp_ch.ready <= calm || ($urandom_range(99) >= 13);
   end

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 55) return LETTERS[$urandom_range(4)];
      if (r < 70) return tag_text[0];
      return 8'($urandom);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_doc();
      int i;
      for (i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
      doc.delete();
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) doc.push_back(s[i]);
   endtask

   // wait for every owed word, then let the block drain
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // write every register once the block has gone quiet
   task automatic configure(input logic [5:0] len, input logic [10:0] lim, input tag_fill_e fill);
      int k;
      int w;
      logic [63:0] tag_word;
      settle();
      for (k = 0; k < MAX_TAG_BYTES; k++) begin
         if (fill == TAG_ONES) tag_text[k] = 8'hFF;
         else if (fill == TAG_RANDOM)
            tag_text[k] = ($urandom_range(99) < 70) ? LETTERS[$urandom_range(4)] : 8'($urandom);
      end
      for (w = 0; w < 4; w++) begin
         for (k = 0; k < 8; k++) tag_word[8*k +: 8] = tag_text[8*w + k];
         csr_write(CSR_TAG_0_7 + 3'(w), tag_word);
      end
      csr_write(CSR_TAG_LEN, 64'(len));
      csr_write(CSR_LIMIT, 64'(lim));
      tag_len_used = (len == 0) ? 1 : ((len > MAX_TAG_BYTES) ? MAX_TAG_BYTES : int'(len));
   endtask

   // mostly well-formed documents: near misses, the tag, a value, maybe "</"
   task automatic make_doc();
      int r;
      int n;
      int j;
      int k;
      r = $urandom_range(99);
      if (r < 12) begin
         n = $urandom_range(1, 10);
         repeat (n) doc.push_back(8'($urandom));
      end else begin
         n = $urandom_range(0, 4);
         repeat (n) begin
            if ($urandom_range(2) == 0) begin
               j = $urandom_range(0, tag_len_used - 1);
               for (k = 0; k < j; k++) doc.push_back(tag_text[k]);
            end
            doc.push_back(pick_byte());
         end
         if (r < 90)
            for (k = 0; k < tag_len_used; k++) doc.push_back(tag_text[k]);
         n = $urandom_range(0, 12);
         repeat (n) doc.push_back(pick_byte());
         if ($urandom_range(1)) begin
            doc.push_back(CHAR_LT);
            doc.push_back(CHAR_SLASH);
         end
         n = $urandom_range(0, 3);
         repeat (n) doc.push_back(pick_byte());
      end
      if (doc.size() == 0) doc.push_back(pick_byte());
   endtask

   task automatic run_phase(input logic [5:0] len, input logic [10:0] lim, input tag_fill_e fill);
      int stop;
      configure(len, lim, fill);
      stop = items_sent + PHASE_ITEMS;
      while (items_sent < stop) begin
         make_doc();
         send_doc();
      end
   endtask

   initial begin
      int i;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_TAG_0_7;
      csr_ch.data      = 64'h0;
      calm             = 1'b0;
      items_sent       = 0;
      tag_len_used     = 1;
      for (i = 0; i < MAX_TAG_BYTES; i++) tag_text[i] = 8'h00;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one-byte zero tag, held '<' at the end of the document
      doc.push_back(8'h00);
      queue_text("v<");
      send_doc();
      // one-byte document, tag never found
      doc.push_back(8'hFF);
      send_doc();

      // tag "aab"
      for (i = 0; i < MAX_TAG_BYTES; i++) tag_text[i] = 8'($urandom);
      tag_text[0] = 8'h61;
      tag_text[1] = 8'h61;
      tag_text[2] = 8'h62;
      configure(6'd3, 11'd1024, TAG_KEEP);
      csr_write(CSR_SPARE_6, {$urandom, $urandom});
      csr_write(CSR_SPARE_7, {$urandom, $urandom});
      // '<' without '/', then a close, then a byte after completion
      queue_text("aab<y</q");
      send_doc();
      // partial match broken by a byte that restarts it
      queue_text("aaaabw<");
      send_doc();
      // held '<' reaching the limit
      configure(6'd3, 11'd2, TAG_KEEP);
      queue_text("aabx<y");
      send_doc();
      // zero limit: truncated straight after the tag
      configure(6'd3, 11'd0, TAG_KEEP);
      queue_text("aabq");
      send_doc();

      // random documents over a spread of settings
      run_phase(6'd3, 11'd4, TAG_RANDOM);
      run_phase(6'd1, 11'd1, TAG_RANDOM);

      // no idling on either side here; limit above the maximum saturates
      calm = 1'b1;
      run_phase(6'd2, 11'd2047, TAG_RANDOM);
      calm = 1'b0;

      run_phase(6'd0, 11'd0, TAG_RANDOM);
      run_phase(6'd5, 11'd3, TAG_RANDOM);

      run_phase(6'd63, 11'd1024, TAG_ONES);
      run_phase(6'($urandom_range(1, 8)), 11'($urandom_range(1, 12)), TAG_RANDOM);

      settle();
      if (error_count == 0 && words_owed == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
